// ===== rtl/core/ctrm_pkg.sv =====
// Shared types and constants for the counter-to-rate meter.
// Used by ctrm_alu and counter_to_rate_meter; depends on nothing else.
`default_nettype none

package ctrm_pkg;

  // Field widths.
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned TIME_W  = 64;
  localparam int unsigned RATE_W  = 64;
  localparam int unsigned STAT_W  = 2;

  // The shared subtractor is one bit wider than a sample so that it can take
  // the shifted partial remainder of the long division.
  localparam int unsigned ALU_W = VALUE_W + 1;

  // Fixed point scaling: timestamps carry TIME_FRAC_BITS fraction bits and
  // the rate carries RATE_FRAC_BITS. The numerator is delta shifted by both.
  localparam int unsigned TIME_FRAC_BITS = 30;
  localparam int unsigned RATE_FRAC_BITS = 16;
  localparam int unsigned SCALE_SHIFT    = TIME_FRAC_BITS + RATE_FRAC_BITS;

  // A counter whose old value fits in this many bits is taken to wrap there.
  localparam int unsigned WRAP_NARROW_W = 32;

  // One quotient bit per division step.
  localparam int unsigned DIV_STEPS = RATE_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [STAT_W-1:0] {
    STATUS_RATE     = 2'd0,
    STATUS_BAD_TIME = 2'd1,
    STATUS_FIRST    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TCMP,
    S_DELTA,
    S_SAT,
    S_DIV,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/ctrm_alu.sv =====
// Shared subtract and compare unit of the counter-to-rate meter.
// Depends on ctrm_pkg for its width.
`default_nettype none

module ctrm_alu (
  input  wire logic [ctrm_pkg::ALU_W-1:0] op_a,
  input  wire logic [ctrm_pkg::ALU_W-1:0] op_b,
  output logic      [ctrm_pkg::ALU_W-1:0] diff,
  output logic                            borrow
);

  // A borrow means op_a is below op_b.
  assign {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};

endmodule

`default_nettype wire

// ===== rtl/core/counter_to_rate_meter.sv =====
// Top level of the counter-to-rate meter: sequencer, state and datapath.
// Depends on ctrm_pkg and ctrm_alu.
`default_nettype none

// The meter takes one counter reading with its timestamp per request and
// returns one result per request. It holds the previous reading and time.
// A timestamp that does not move forward clears the held sample and returns
// status 1; a reading taken while no sample is held is stored and returns
// status 2; otherwise the counter increase since the held sample (wrapping
// at 32 bits when the old reading fits in 32 bits, else at 64 bits) is
// divided by the elapsed time and returned with status 0 as counts per
// second in unsigned Q48.16, saturating to all ones. Timestamps count in
// units of 2^-30 s. All arithmetic runs through one 65-bit subtractor that
// a small sequencer reuses: a time compare, a counter delta, an overflow
// check and then one restoring long division step per quotient bit. A rate
// result that the overflow check finds to saturate skips the division; a
// status 1 or status 2 result skips the delta, the check and the division.
// The result stays on the output until it is taken, and in_stall is high
// from the accepted request until its result has been taken, so one
// request is worked on at a time.
module counter_to_rate_meter (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] in_sample_value,
  input  wire logic [63:0] in_sample_time,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [63:0]      out_rate
);

  localparam int unsigned VW = ctrm_pkg::VALUE_W;
  localparam int unsigned AW = ctrm_pkg::ALU_W;
  localparam int unsigned NW = 2 * VW;

  ctrm_pkg::state_t state_r, state_nxt;

  // Held sample.
  logic [VW-1:0] prev_count_r;
  logic [ctrm_pkg::TIME_W-1:0] prev_time_r;

  // Request being worked on.
  logic [VW-1:0] value_r;
  logic [ctrm_pkg::TIME_W-1:0] time_r;

  // Division registers: divisor, partial remainder, remaining numerator
  // bits and the quotient built so far.
  logic [ctrm_pkg::TIME_W-1:0] dt_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] lo_r;
  logic [ctrm_pkg::RATE_W-1:0] quo_r;
  logic [ctrm_pkg::STEP_W-1:0] step_r;

  // Result register.
  ctrm_pkg::status_t status_r;
  logic [ctrm_pkg::RATE_W-1:0] rate_r;

  logic [AW-1:0] alu_a, alu_b, alu_diff;
  logic          alu_borrow;

  logic          in_take, out_take;
  logic          time_bad, no_sample, wrap_narrow;
  logic [VW-1:0] delta;
  logic [NW-1:0] numer;
  logic [AW-1:0] rem_shift;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  ctrm_alu u_alu (
    .op_a   (alu_a),
    .op_b   (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  // In the time compare cycle: a borrow or a zero difference means the new
  // timestamp is not later than the held one.
  assign time_bad  = alu_borrow || (alu_diff == '0);
  assign no_sample = (prev_time_r == '0);

  // In the delta cycle: when the counter went down and the old reading fits
  // in 32 bits, the new reading is below it too, so the 32-bit wrapped
  // increase is just the low half of the 64-bit difference.
  assign wrap_narrow = alu_borrow &&
                       (prev_count_r[VW-1:ctrm_pkg::WRAP_NARROW_W] == '0);
  assign delta = wrap_narrow ?
                 {{(VW - ctrm_pkg::WRAP_NARROW_W){1'b0}},
                  alu_diff[ctrm_pkg::WRAP_NARROW_W-1:0]} :
                 alu_diff[VW-1:0];

  // The scaled numerator is delta shifted left by the fixed point scale; its
  // upper half starts the remainder and its lower half feeds the steps.
  assign numer = {{VW{1'b0}}, delta} << ctrm_pkg::SCALE_SHIFT;

  // Each division step brings down the next numerator bit.
  assign rem_shift = {rem_r, lo_r[VW-1]};

  // Subtractor operand selection.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_r)
      ctrm_pkg::S_TCMP: begin
        alu_a = {1'b0, time_r};
        alu_b = {1'b0, prev_time_r};
      end
      ctrm_pkg::S_DELTA: begin
        alu_a = {1'b0, value_r};
        alu_b = {1'b0, prev_count_r};
      end
      ctrm_pkg::S_SAT: begin
        // The quotient overflows 64 bits exactly when the upper numerator
        // half is not below the divisor.
        alu_a = {1'b0, rem_r};
        alu_b = {1'b0, dt_r};
      end
      ctrm_pkg::S_DIV: begin
        alu_a = rem_shift;
        alu_b = {1'b0, dt_r};
      end
      ctrm_pkg::S_IDLE, ctrm_pkg::S_OUT: begin
        alu_a = '0;
        alu_b = '0;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ctrm_pkg::S_IDLE: begin
        if (in_take) state_nxt = ctrm_pkg::S_TCMP;
      end
      ctrm_pkg::S_TCMP: begin
        if (time_bad || no_sample) state_nxt = ctrm_pkg::S_OUT;
        else                       state_nxt = ctrm_pkg::S_DELTA;
      end
      ctrm_pkg::S_DELTA: begin
        state_nxt = ctrm_pkg::S_SAT;
      end
      ctrm_pkg::S_SAT: begin
        if (!alu_borrow) state_nxt = ctrm_pkg::S_OUT;
        else             state_nxt = ctrm_pkg::S_DIV;
      end
      ctrm_pkg::S_DIV: begin
        if (step_r == '0) state_nxt = ctrm_pkg::S_OUT;
      end
      ctrm_pkg::S_OUT: begin
        if (out_take) state_nxt = ctrm_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ctrm_pkg::S_IDLE;
      end
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ctrm_pkg::S_IDLE: in_stall  = 1'b0;
      ctrm_pkg::S_OUT:  out_valid = 1'b1;
      ctrm_pkg::S_TCMP, ctrm_pkg::S_DELTA, ctrm_pkg::S_SAT,
      ctrm_pkg::S_DIV: begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
      end
      default: begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
      end
    endcase
  end

  assign out_status = status_r;
  assign out_rate   = rate_r;

  // Control state and the held sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ctrm_pkg::S_IDLE;
      prev_count_r <= '0;
      prev_time_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ctrm_pkg::S_TCMP) begin
        if (time_bad) begin
          prev_count_r <= '0;
          prev_time_r  <= '0;
        end else if (no_sample) begin
          prev_count_r <= value_r;
          prev_time_r  <= time_r;
        end
      end else if (state_r == ctrm_pkg::S_DELTA) begin
        // Elapsed time was captured in the time compare state and delta is
        // captured now, so the new sample can replace the held one.
        prev_count_r <= value_r;
        prev_time_r  <= time_r;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ctrm_pkg::S_IDLE: begin
        if (in_take) begin
          value_r <= in_sample_value;
          time_r  <= in_sample_time;
        end
      end
      ctrm_pkg::S_TCMP: begin
        dt_r     <= alu_diff[ctrm_pkg::TIME_W-1:0];
        rate_r   <= '0;
        if (time_bad)       status_r <= ctrm_pkg::STATUS_BAD_TIME;
        else if (no_sample) status_r <= ctrm_pkg::STATUS_FIRST;
        else                status_r <= ctrm_pkg::STATUS_RATE;
      end
      ctrm_pkg::S_DELTA: begin
        rem_r <= numer[NW-1:VW];
        lo_r  <= numer[VW-1:0];
      end
      ctrm_pkg::S_SAT: begin
        quo_r  <= '0;
        step_r <= ctrm_pkg::STEP_W'(ctrm_pkg::DIV_STEPS - 1);
        if (!alu_borrow) rate_r <= '1;
      end
      ctrm_pkg::S_DIV: begin
        // Restoring step: keep the difference when the shifted remainder
        // is not below the divisor, and shift in the quotient bit.
        if (!alu_borrow) rem_r <= alu_diff[VW-1:0];
        else             rem_r <= rem_shift[VW-1:0];
        lo_r   <= {lo_r[VW-2:0], 1'b0};
        quo_r  <= {quo_r[ctrm_pkg::RATE_W-2:0], !alu_borrow};
        step_r <= step_r - 1'b1;
        if (step_r == '0) rate_r <= {quo_r[ctrm_pkg::RATE_W-2:0], !alu_borrow};
      end
      ctrm_pkg::S_OUT: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
